/* sv/p31mc_pkg.sv */
// p31mc_pkg: shared constants, types and the prbs31 word tap table
// used by every module of the prbs31 multilane checker; no dependencies
package p31mc_pkg;

  localparam int MAX_LANES     = 4;
  localparam int LANES_DEFAULT = 4;
  localparam int WORD_W        = 32;
  localparam int LFSR_W        = 31;
  localparam int TAP_HI        = 30;
  localparam int TAP_LO        = 27;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [LFSR_W-1:0] LFSR_RESET = {LFSR_W{1'b1}};

  // per word bit: which lfsr state bits are xored into it after a 32-bit advance
  typedef logic [WORD_W-1:0][LFSR_W-1:0] word_taps_t;

  // transaction handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0]    expected;
    logic [MAX_LANES-1:0] mismatch;
  } p31mc_entry_t;

  // symbolic run of the serial lfsr, evaluated at elaboration
  function automatic word_taps_t build_word_taps();
    logic [LFSR_W-1:0] sym [LFSR_W];
    logic [LFSR_W-1:0] b;
    word_taps_t        taps;
    for (int k = 0; k < LFSR_W; k++) begin
      sym[k] = LFSR_W'(1) << k;
    end
    taps = '0;
    for (int i = 0; i < WORD_W; i++) begin
      b = sym[TAP_HI] ^ sym[TAP_LO];
      for (int k = LFSR_W - 1; k > 0; k--) begin
        sym[k] = sym[k-1];
      end
      sym[0] = b;
      taps[WORD_W-1-i] = b;
    end
    return taps;
  endfunction

  localparam word_taps_t WORD_TAPS = build_word_taps();

  // one xor reduction per word bit, all independent
  function automatic logic [WORD_W-1:0] prbs_word(logic [LFSR_W-1:0] s);
    logic [WORD_W-1:0] w;
    for (int j = 0; j < WORD_W; j++) begin
      w[j] = ^(s & WORD_TAPS[j]);
    end
    return w;
  endfunction

endpackage

/* sv/prbs31_multilane_checker.sv */
// prbs31_multilane_checker: top level of the prbs31 multilane checker
// depends on p31mc_pkg, p31mc_front, p31mc_queue, p31mc_back
//
// usage
// - input channel (in_valid/in_ready): one transaction carries one received
//   32-bit word per lane; all lanes are checked against one shared prbs31
//   word (x^31 + x^28 + 1), first generated bit in the msb
// - output channel (out_valid/out_ready): one transaction per input, with the
//   expected word, a per-lane mismatch mask and the saturating error count
//   of every lane after that word; lanes at or above LANES read zero
// - cfg_we/cfg_wdata: writes the 31-bit start state, which is loaded into the
//   lfsr at once; error counts are kept; write only while idle
// - path: an accepted input goes into the queue, then into the output register
//   when the output is free
// - throughput: 1 transaction per cycle while the queue is not full; the 32-bit advance is a single
//   xor network in the front, counters live in the back
// - a 2-entry queue between front and back plus the output register let the
//   input keep flowing while a result waits; when the receiver stalls, the
//   queue takes up to two more transactions, then in_ready drops until the
//   receiver takes the held result
// - reset: lfsr back to all ones, error counts cleared, queue and output empty
module prbs31_multilane_checker #(
  parameter int LANES       = p31mc_pkg::LANES_DEFAULT,
  parameter int QUEUE_DEPTH = p31mc_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [p31mc_pkg::LFSR_W-1:0]   cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [p31mc_pkg::WORD_W-1:0]   lane0_word,
  input  logic [p31mc_pkg::WORD_W-1:0]   lane1_word,
  input  logic [p31mc_pkg::WORD_W-1:0]   lane2_word,
  input  logic [p31mc_pkg::WORD_W-1:0]   lane3_word,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [p31mc_pkg::WORD_W-1:0]   expected_word,
  output logic [p31mc_pkg::MAX_LANES-1:0] mismatch_mask,
  output logic [p31mc_pkg::WORD_W-1:0]   lane0_errors,
  output logic [p31mc_pkg::WORD_W-1:0]   lane1_errors,
  output logic [p31mc_pkg::WORD_W-1:0]   lane2_errors,
  output logic [p31mc_pkg::WORD_W-1:0]   lane3_errors
);
  import p31mc_pkg::*;

  logic [MAX_LANES-1:0][WORD_W-1:0] words;
  logic [MAX_LANES-1:0][WORD_W-1:0] errors;

  // front to queue
  logic         q_push;
  logic         q_full;
  p31mc_entry_t q_in;

  // queue to back
  logic         q_pop;
  logic         q_not_empty;
  p31mc_entry_t q_head;

  assign words = {lane3_word, lane2_word, lane1_word, lane0_word};

  // front: lfsr advance and compare, one transaction per cycle while the queue is not full
  p31mc_front #(
    .LANES (LANES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .words     (words),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // decoupling queue
  p31mc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back: error counting and output register
  p31mc_back #(
    .LANES (LANES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .expected_word (expected_word),
    .mismatch_mask (mismatch_mask),
    .errors        (errors)
  );

  assign lane0_errors = errors[0];
  assign lane1_errors = errors[1];
  assign lane2_errors = errors[2];
  assign lane3_errors = errors[3];

endmodule

/* sv/p31mc_front.sv */
// p31mc_front: lfsr generator and per-lane word compare
// depends on p31mc_pkg
module p31mc_front #(
  parameter int LANES = p31mc_pkg::LANES_DEFAULT
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               cfg_we,
  input  logic [p31mc_pkg::LFSR_W-1:0]                       cfg_wdata,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  logic [p31mc_pkg::MAX_LANES-1:0][p31mc_pkg::WORD_W-1:0] words,
  input  logic                                               q_full,
  output logic                                               q_push,
  output p31mc_pkg::p31mc_entry_t                            q_entry
);
  import p31mc_pkg::*;

  logic [LFSR_W-1:0] lfsr;
  logic [WORD_W-1:0] expected;

  assign expected = prbs_word(lfsr);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.expected = expected;
    q_entry.mismatch = '0;
    for (int n = 0; n < MAX_LANES; n++) begin
      if (n < LANES) begin
        q_entry.mismatch[n] = (words[n] != expected);
      end
    end
  end

  // new state is the last 31 bits generated
  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_RESET;
    end else if (cfg_we) begin
      lfsr <= cfg_wdata;
    end else if (q_push) begin
      lfsr <= expected[LFSR_W-1:0];
    end
  end

endmodule

/* sv/p31mc_queue.sv */
// p31mc_queue: small fifo between front and back
// depends on p31mc_pkg
module p31mc_queue #(
  parameter int DEPTH = p31mc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  p31mc_pkg::p31mc_entry_t push_entry,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output p31mc_pkg::p31mc_entry_t head
);
  import p31mc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  p31mc_entry_t   mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/p31mc_back.sv */
// p31mc_back: saturating error counters and output register
// depends on p31mc_pkg
module p31mc_back #(
  parameter int LANES = p31mc_pkg::LANES_DEFAULT
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   q_not_empty,
  input  p31mc_pkg::p31mc_entry_t                                q_head,
  output logic                                                   q_pop,
  output logic                                                   out_valid,
  input  logic                                                   out_ready,
  output logic [p31mc_pkg::WORD_W-1:0]                           expected_word,
  output logic [p31mc_pkg::MAX_LANES-1:0]                        mismatch_mask,
  output logic [p31mc_pkg::MAX_LANES-1:0][p31mc_pkg::WORD_W-1:0] errors
);
  import p31mc_pkg::*;

  p31mc_entry_t out_entry;

  // load a new transaction when the output slot is free or being emptied
  assign q_pop         = q_not_empty && (!out_valid || out_ready);
  assign expected_word = out_entry.expected;
  assign mismatch_mask = out_entry.mismatch;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_entry <= q_head;
    end
  end

  // counters change only on a load, so they match the held output
  for (genvar n = 0; n < MAX_LANES; n++) begin : g_lane
    if (n < LANES) begin : g_active
      logic [WORD_W-1:0] count;
      always_ff @(posedge clk) begin
        if (rst) begin
          count <= '0;
        end else if (q_pop && q_head.mismatch[n] && (count != {WORD_W{1'b1}})) begin
          count <= count + WORD_W'(1);
        end
      end
      assign errors[n] = count;
    end else begin : g_unused
      assign errors[n] = '0;
    end
  end

endmodule
